FILE: hw/rtl/rps_pkg.sv
// shared types and constants for the rock-paper-scissors automaton step
package rps_pkg;

  // configuration register widths and indexes
  localparam int GRID_W_BITS   = 9;
  localparam int GRID_H_BITS   = 13;
  localparam int THR_BITS      = 4;
  localparam int REG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [REG_IDX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD   = 2'd2;

  localparam logic [GRID_W_BITS-1:0] RESET_GRID_WIDTH  = 9'd256;
  localparam logic [GRID_H_BITS-1:0] RESET_GRID_HEIGHT = 13'd256;
  localparam logic [THR_BITS-1:0]    RESET_THRESHOLD   = 4'd3;

  // grid geometry
  localparam int DEF_MAX_WIDTH = 256;
  localparam int ROW_BITS      = 13;
  localparam int OUT_ROW_BITS  = 12;
  localparam logic [ROW_BITS-1:0] MAX_HEIGHT = 13'd4096;
  localparam logic [ROW_BITS-1:0] ROW_LIMIT  = 13'd8191;

  // output queue
  localparam int FIFO_DEPTH = 4;

  // opcodes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // cell states
  typedef logic [1:0] state_t;
  localparam state_t ST_ROCK     = 2'd0;
  localparam state_t ST_PAPER    = 2'd1;
  localparam state_t ST_SCISSORS = 2'd2;
  localparam state_t ST_INVALID  = 2'd3;

  // window rows within a column
  localparam int ROW_TOP = 0;
  localparam int ROW_MID = 1;
  localparam int ROW_BOT = 2;

  // one window column, indexed by row; window indexed by column, oldest first
  typedef logic [2:0][1:0] col_t;
  typedef col_t [2:0]      window_t;

  // per-item control handed down the pipeline
  typedef struct packed {
    logic has_result;
    logic top_clip;
    logic bot_clip;
    logic left_clip;
    logic right_clip;
    logic last;
  } meta_t;

  typedef struct packed {
    state_t next_state;
    logic   last_of_frame;
  } out_item_t;

endpackage

FILE: hw/rtl/rps_in_if.sv
// input stream channel: grid cells and drain items
interface rps_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] cell_state;

  modport source (output valid, output opcode, output cell_state, input ready);
  modport sink   (input valid, input opcode, input cell_state, output ready);
endinterface

FILE: hw/rtl/rps_out_if.sv
// output stream channel: updated cell states
interface rps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] next_state;
  logic       last_of_frame;

  modport source (output valid, output next_state, output last_of_frame, input ready);
  modport sink   (input valid, input next_state, input last_of_frame, output ready);
endinterface

FILE: hw/rtl/rock_paper_scissors_automaton_step.sv
// top level: one generation of the rock-paper-scissors automaton over a raster grid
//
//   channel   dir  handshake          payload
//   cells     in   valid/ready        opcode, cell_state
//   results   out  valid/ready        next_state, last_of_frame
//   config    in   write_enable       reg_index, write_data
//
// one item per cycle sustained while results are taken; the result released by an item
// reaches the output queue through the line store read, window shift and rule stages
// the line stores are rams with a registered read, which sets the first stage
// reset clears counters, window and queue; line stores are not cleared
// ready drops only when the queued plus in-flight items fill the 4-entry output queue
module rock_paper_scissors_automaton_step
  import rps_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  rps_in_if.sink                   cells,
  rps_out_if.source                results,
  input  logic                     write_enable,
  input  logic [REG_IDX_BITS-1:0]  reg_index,
  input  logic [CFG_DATA_BITS-1:0] write_data
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 2);
  localparam int CMPW      = (WW > GRID_W_BITS) ? WW : GRID_W_BITS;
  localparam int PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS  = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_BITS  = $clog2(FIFO_DEPTH + 3);

  // configuration
  logic [GRID_W_BITS-1:0] grid_width;
  logic [GRID_H_BITS-1:0] grid_height;
  logic [THR_BITS-1:0]    threshold;
  logic                   cfg_hit;

  logic [CMPW-1:0]     w_wide;
  logic [WW-1:0]       w_eff;
  logic [ROW_BITS-1:0] h_eff;

  assign cfg_hit = write_enable && (reg_index == REG_GRID_WIDTH ||
                                    reg_index == REG_GRID_HEIGHT ||
                                    reg_index == REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RESET_GRID_WIDTH;
      grid_height <= RESET_GRID_HEIGHT;
      threshold   <= RESET_THRESHOLD;
    end else if (write_enable) begin
      case (reg_index)
        REG_GRID_WIDTH:  grid_width  <= write_data[GRID_W_BITS-1:0];
        REG_GRID_HEIGHT: grid_height <= write_data[GRID_H_BITS-1:0];
        REG_THRESHOLD:   threshold   <= write_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_wide = CMPW'(grid_width);
    if (grid_width == '0) begin
      w_wide = CMPW'(1);
    end else if (w_wide > CMPW'(MAX_WIDTH)) begin
      w_wide = CMPW'(MAX_WIDTH);
    end
    w_eff = WW'(w_wide);
  end

  always_comb begin
    h_eff = ROW_BITS'(grid_height);
    if (grid_height == '0) begin
      h_eff = ROW_BITS'(1);
    end else if (h_eff > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end
  end

  // stage a: counters and line store read
  logic [CW-1:0]           in_col;
  logic [ROW_BITS-1:0]     in_row;
  logic [CW-1:0]           out_col;
  logic [OUT_ROW_BITS-1:0] out_row;
  logic [WW-1:0]           lag;

  logic   fire, take, frame_open, col_wrap, oc_last, or_last, has_res;
  state_t v_in;
  meta_t  meta_a;

  assign fire       = cells.valid && cells.ready;
  assign frame_open = in_row < h_eff;
  assign take       = fire && !(cells.opcode == OP_DRAIN && frame_open);
  assign v_in       = (!frame_open || cells.cell_state == ST_INVALID) ? ST_ROCK
                                                                       : cells.cell_state;
  assign col_wrap   = WW'(in_col) + WW'(1) >= w_eff;
  assign has_res    = lag >= w_eff + WW'(1);
  assign oc_last    = WW'(out_col) + WW'(1) >= w_eff;
  assign or_last    = ROW_BITS'(out_row) + ROW_BITS'(1) >= h_eff;

  always_comb begin
    meta_a.has_result = has_res;
    meta_a.top_clip   = out_row == '0;
    meta_a.bot_clip   = or_last;
    meta_a.left_clip  = out_col == '0;
    meta_a.right_clip = oc_last;
    meta_a.last       = oc_last && or_last;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      lag     <= '0;
    end else if (take) begin
      if (has_res && meta_a.last) begin
        // frame done: start the next one clean
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        lag     <= '0;
      end else begin
        in_col <= col_wrap ? '0 : in_col + CW'(1);
        if (col_wrap && in_row != ROW_LIMIT) begin
          in_row <= in_row + ROW_BITS'(1);
        end
        if (!has_res) begin
          lag <= lag + WW'(1);
        end else if (oc_last) begin
          out_col <= '0;
          out_row <= out_row + OUT_ROW_BITS'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // stage b: line store data back, write-back and window shift
  logic          s1_valid;
  state_t        s1_v;
  logic [CW-1:0] s1_col;
  meta_t         s1_meta;
  logic          s1_byp;
  state_t        s1_byp_top;
  state_t        s1_byp_mid;

  state_t up_rdata, mid_rdata, top_eff, mid_eff;
  col_t   new_col;
  logic   win_stale;

  // forward when the previous item writes the column being read
  assign top_eff = s1_byp ? s1_byp_top : up_rdata;
  assign mid_eff = s1_byp ? s1_byp_mid : mid_rdata;

  always_comb begin
    new_col          = '0;
    new_col[ROW_TOP] = top_eff;
    new_col[ROW_MID] = mid_eff;
    new_col[ROW_BOT] = s1_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    s1_v       <= v_in;
    s1_col     <= in_col;
    s1_meta    <= meta_a;
    s1_byp     <= s1_valid && s1_col == in_col;
    s1_byp_top <= mid_eff;
    s1_byp_mid <= s1_v;
  end

  rps_ram #(
    .WIDTH ($bits(state_t)),
    .DEPTH (MAX_WIDTH)
  ) u_upper_row (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (mid_eff),
    .raddr (in_col),
    .rdata (up_rdata)
  );

  rps_ram #(
    .WIDTH ($bits(state_t)),
    .DEPTH (MAX_WIDTH)
  ) u_middle_row (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_v),
    .raddr (in_col),
    .rdata (mid_rdata)
  );

  // the window is cleared lazily: the shift after a restart pulls in zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      win_stale <= 1'b0;
    end else if (cfg_hit) begin
      win_stale <= 1'b1;
    end else if (s1_valid) begin
      win_stale <= s1_meta.has_result && s1_meta.last;
    end
  end

  col_t    col_q0, col_q1, col_q2;
  window_t win;

  assign win = {col_q2, col_q1, col_q0};

  rps_win_cell u_cell0 (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_valid),
    .clr   (win_stale),
    .din   (col_q1),
    .q     (col_q0)
  );

  rps_win_cell u_cell1 (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_valid),
    .clr   (win_stale),
    .din   (col_q2),
    .q     (col_q1)
  );

  rps_win_cell u_cell2 (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_valid),
    .clr   (1'b0),
    .din   (new_col),
    .q     (col_q2)
  );

  // stage c: rule on the shifted window, into the output queue
  logic   s2_valid;
  meta_t  s2_meta;
  state_t rule_state;
  logic   push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_meta <= s1_meta;
  end

  rps_rule u_rule (
    .win        (win),
    .meta       (s2_meta),
    .threshold  (threshold),
    .next_state (rule_state)
  );

  assign push = s2_valid && s2_meta.has_result;
  assign pop  = results.valid && results.ready;

  out_item_t           fifo_mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] fifo_count;
  logic [OCC_BITS-1:0] occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + CNT_BITS'(1);
      end else if (pop && !push) begin
        fifo_count <= fifo_count - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{next_state: rule_state, last_of_frame: s2_meta.last};
    end
  end

  // every in-flight item holds a slot in the queue
  assign occ = OCC_BITS'(fifo_count) + OCC_BITS'(s1_valid) + OCC_BITS'(s2_valid);

  assign cells.ready           = occ < OCC_BITS'(FIFO_DEPTH);
  assign results.valid         = fifo_count != '0;
  assign results.next_state    = fifo_mem[rd_ptr].next_state;
  assign results.last_of_frame = fifo_mem[rd_ptr].last_of_frame;

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_BITS'(FIFO_DEPTH))
    else $error("output queue oversubscribed");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && has_res && meta_a.last && !cfg_hit |=>
      in_col == '0 && in_row == '0 && lag == '0 && out_col == '0 && out_row == '0)
    else $error("counters not cleared after last cell of frame");

  a_stale: assert property (@(posedge clk) disable iff (rst)
    push && s2_meta.last |-> win_stale)
    else $error("window not marked for clearing at end of frame");

endmodule

FILE: hw/rtl/rps_ram.sv
// generic single-write, single-read ram with registered read data
module rps_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rps_win_cell.sv
// one column cell of the 3x3 neighbour window, shifts toward the older side
module rps_win_cell
  import rps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic clr,
  input  col_t din,
  output col_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= clr ? '0 : din;
    end
  end

endmodule

FILE: hw/rtl/rps_rule.sv
// neighbour count with edge clipping and the predator conversion rule
module rps_rule
  import rps_pkg::*;
(
  input  window_t             win,
  input  meta_t               meta,
  input  logic [THR_BITS-1:0] threshold,
  output state_t              next_state
);

  state_t              center;
  state_t              pred;
  logic [THR_BITS-1:0] cnt;

  always_comb begin
    center = (win[1][ROW_MID] == ST_INVALID) ? ST_ROCK : win[1][ROW_MID];
    case (center)
      ST_ROCK:     pred = ST_PAPER;
      ST_PAPER:    pred = ST_SCISSORS;
      ST_SCISSORS: pred = ST_ROCK;
      default:     pred = ST_PAPER;
    endcase
  end

  always_comb begin
    logic skip;
    cnt = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        skip = (r == ROW_MID && c == 1) ||
               (r == ROW_TOP && meta.top_clip) ||
               (r == ROW_BOT && meta.bot_clip) ||
               (c == 0 && meta.left_clip) ||
               (c == 2 && meta.right_clip);
        if (!skip && win[c][r] == pred) begin
          cnt = cnt + THR_BITS'(1);
        end
      end
    end
  end

  assign next_state = (cnt >= threshold) ? pred : center;

endmodule
